// ===== rtl/tdf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdf_pkg
// Shared types, codes and helpers for the tube digit frame formatter.
// ----------------------------------------------------------------------------
package tdf_pkg;

	localparam int TUBE_COUNT = 6;

	typedef logic [3:0] digit_t;

	localparam digit_t BLANK_DIGIT = 4'd10;

	// request codes
	typedef enum logic [1:0] {
		REQ_TIME  = 2'd0,
		REQ_TEMP  = 2'd1,
		REQ_OCTET = 2'd2,
		REQ_BLANK = 2'd3
	} req_type_t;

	// register indexes
	localparam logic CFG_HOUR_FORMAT = 1'b0;
	localparam logic CFG_TEMP_PREC   = 1'b1;

	// temperature precision codes (code 3 behaves as hundredths)
	localparam logic [1:0] TDEC_WHOLE  = 2'd0;
	localparam logic [1:0] TDEC_TENTHS = 2'd1;
	localparam logic [1:0] TDEC_HUNDR  = 2'd2;

	localparam logic [13:0] TEMP_CLAMP = 14'd9999;

	// one formatted frame, digit[0] is the leftmost tube
	typedef struct packed {
		digit_t [TUBE_COUNT-1:0] digit;
		logic                    colon_on;
		logic                    colon_driven;
	} frame_t;

	// x / 10 for x <= 99 by reciprocal multiply (205 / 2048)
	function automatic digit_t div10_small(input logic [6:0] x);
		logic [17:0] p;
		p = 18'(x) * 18'd205;
		return p[14:11];
	endfunction

endpackage : tdf_pkg
`default_nettype wire

// ===== rtl/tdf_time_fmt.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdf_time_fmt
// HH MM SS digits, 24-hour or 12-hour with blanked leading zero.
// ----------------------------------------------------------------------------
module tdf_time_fmt (
	input  wire logic          hour_format_24,
	input  wire logic [4:0]    hour,
	input  wire logic [5:0]    minute,
	input  wire logic [5:0]    second,
	output tdf_pkg::frame_t    frame
);
	import tdf_pkg::*;

	logic [4:0] h12;
	logic [4:0] h_sel;
	digit_t     h_tens, m_tens, s_tens;
	logic [4:0] h_ones;
	logic [5:0] m_ones, s_ones;

	always_comb begin
		// hour mod 12, with 0 shown as 12
		if (hour >= 5'd24) begin
			h12 = hour - 5'd24;
		end else if (hour >= 5'd12) begin
			h12 = hour - 5'd12;
		end else begin
			h12 = hour;
		end
		if (h12 == 5'd0) begin
			h12 = 5'd12;
		end
		h_sel = hour_format_24 ? hour : h12;
	end

	assign h_tens = div10_small(7'(h_sel));
	assign m_tens = div10_small(7'(minute));
	assign s_tens = div10_small(7'(second));
	assign h_ones = h_sel - (5'(h_tens) * 5'd10);
	assign m_ones = minute - (6'(m_tens) * 6'd10);
	assign s_ones = second - (6'(s_tens) * 6'd10);

	always_comb begin
		frame.digit[0]     = (!hour_format_24 && h_sel < 5'd10) ? BLANK_DIGIT : h_tens;
		frame.digit[1]     = h_ones[3:0];
		frame.digit[2]     = m_tens;
		frame.digit[3]     = m_ones[3:0];
		frame.digit[4]     = s_tens;
		frame.digit[5]     = s_ones[3:0];
		frame.colon_on     = 1'b0;
		frame.colon_driven = 1'b0;
	end

endmodule : tdf_time_fmt
`default_nettype wire

// ===== rtl/tdf_temp_fmt.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdf_temp_fmt
// Temperature readout: clamped magnitude, decimal rounding, negative blink.
// ----------------------------------------------------------------------------
module tdf_temp_fmt (
	input  wire logic [1:0]        temp_prec,
	input  wire logic signed [15:0] centi_degrees,
	input  wire logic [31:0]       time_ms,
	output tdf_pkg::frame_t        frame
);
	import tdf_pkg::*;

	// BCD increment: {carry, digit}
	function automatic logic [4:0] bcd_inc(input digit_t d, input logic c);
		logic [4:0] r;
		if (c && d == 4'd9) begin
			r = {1'b1, 4'd0};
		end else begin
			r = {1'b0, d + {3'b000, c}};
		end
		return r;
	endfunction

	logic        neg;
	logic [16:0] mag_full;
	logic [13:0] mag;

	// blink phase: bit 0 of time_ms/250 == (time_ms mod 500) >= 250
	logic [16:0] ms_sum;
	logic [11:0] ms_f1;
	logic [9:0]  ms_f2;
	logic [9:0]  ms_mod;
	logic        off_phase;

	logic [29:0] p10;
	logic [25:0] p100;
	logic [26:0] p1000;
	logic [9:0]  q10;
	logic [6:0]  q100;
	digit_t      q1000;
	logic [13:0] u_w;
	logic [9:0]  te_w;
	logic [6:0]  h_w;
	digit_t      d_u, d_te, d_h, d_th;

	logic [4:0]  t0, t1, t2;
	logic [4:0]  w0, w1;

	assign neg      = centi_degrees[15];
	assign mag_full = neg ? (17'h10000 - {1'b0, centi_degrees}) : {1'b0, centi_degrees};
	assign mag      = (mag_full > 17'(TEMP_CLAMP)) ? TEMP_CLAMP : mag_full[13:0];

	// 2^8, 2^16, 2^24 mod 500 = 256, 36, 216; then fold by 2^9 mod 500 = 12
	assign ms_sum    = 17'(time_ms[7:0]) + {1'b0, time_ms[15:8], 8'd0}
	                 + 17'(time_ms[23:16]) * 17'd36 + 17'(time_ms[31:24]) * 17'd216;
	assign ms_f1     = 12'(ms_sum[8:0]) + 12'(ms_sum[16:9]) * 12'd12;
	assign ms_f2     = 10'(ms_f1[8:0]) + 10'(ms_f1[11:9]) * 10'd12;
	assign ms_mod    = (ms_f2 >= 10'd500) ? (ms_f2 - 10'd500) : ms_f2;
	assign off_phase = neg && (ms_mod >= 10'd250);

	// decimal digits of the magnitude by reciprocal multiplies
	assign p10   = 30'(mag) * 30'd52429;
	assign p100  = 26'(mag) * 26'd5243;
	assign p1000 = 27'(mag) * 27'd8389;
	assign q10   = p10[28:19];
	assign q100  = p100[25:19];
	assign q1000 = p1000[26:23];
	assign u_w   = mag - (14'(q10) * 14'd10);
	assign te_w  = q10 - (10'(q100) * 10'd10);
	assign h_w   = q100 - (7'(q1000) * 7'd10);
	assign d_u   = u_w[3:0];
	assign d_te  = te_w[3:0];
	assign d_h   = h_w[3:0];
	assign d_th  = q1000;

	// tenths: round units into tens digit
	assign t0 = bcd_inc(d_te, d_u >= 4'd5);
	assign t1 = bcd_inc(d_h, t0[4]);
	assign t2 = bcd_inc(d_th, t1[4]);
	// whole degrees: round tens into hundreds digit
	assign w0 = bcd_inc(d_h, d_te >= 4'd5);
	assign w1 = bcd_inc(d_th, w0[4]);

	always_comb begin
		for (int i = 0; i < TUBE_COUNT; i++) begin
			frame.digit[i] = BLANK_DIGIT;
		end
		frame.colon_on     = 1'b0;
		frame.colon_driven = 1'b1;
		if (!off_phase) begin
			if (temp_prec >= TDEC_HUNDR) begin
				frame.digit[5] = d_u;
				frame.digit[4] = d_te;
				frame.digit[3] = d_h;
				if (d_th != 4'd0) begin
					frame.digit[2] = d_th;
				end
				frame.colon_on = 1'b1;
			end else if (temp_prec == TDEC_TENTHS) begin
				frame.digit[4] = t0[3:0];
				frame.digit[3] = t1[3:0];
				if (t2[3:0] != 4'd0 || t2[4]) begin
					frame.digit[2] = t2[3:0];
				end
				frame.colon_on = 1'b1;
			end else begin
				frame.digit[5] = w0[3:0];
				if (w1[3:0] != 4'd0 || w1[4]) begin
					frame.digit[4] = w1[3:0];
				end
			end
		end
	end

endmodule : tdf_temp_fmt
`default_nettype wire

// ===== rtl/tdf_octet_fmt.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdf_octet_fmt
// Right-aligned 0..255 readout without leading zeros.
// ----------------------------------------------------------------------------
module tdf_octet_fmt (
	input  wire logic [7:0]  octet,
	output tdf_pkg::frame_t  frame
);
	import tdf_pkg::*;

	logic [1:0] hund;
	logic [7:0] rest;
	digit_t     tens;
	logic [6:0] ones;

	always_comb begin
		if (octet >= 8'd200) begin
			hund = 2'd2;
		end else if (octet >= 8'd100) begin
			hund = 2'd1;
		end else begin
			hund = 2'd0;
		end
	end

	assign rest = octet - (8'(hund) * 8'd100);
	assign tens = div10_small(rest[6:0]);
	assign ones = rest[6:0] - (7'(tens) * 7'd10);

	always_comb begin
		for (int i = 0; i < TUBE_COUNT; i++) begin
			frame.digit[i] = BLANK_DIGIT;
		end
		frame.digit[5] = ones[3:0];
		if (octet >= 8'd10) begin
			frame.digit[4] = tens;
		end
		if (octet >= 8'd100) begin
			frame.digit[3] = {2'b00, hund};
		end
		frame.colon_on     = 1'b0;
		frame.colon_driven = 1'b1;
	end

endmodule : tdf_octet_fmt
`default_nettype wire

// ===== rtl/tube_digit_frame_formatter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tube_digit_frame_formatter
// Formats one display request into six tube digits plus the colon lamp.
// ----------------------------------------------------------------------------
// Takes one request beat per clock while req_ready is high and returns one
// frame beat for each, in order. The request is captured in an input
// register, formatted by combinational logic (time, temperature and octet
// formatters in parallel, then a select on req_type) and captured in the
// result register, which drives rsp_valid and the frame outputs. Throughput
// is one frame per cycle while rsp_ready is high;
// the input register keeps taking beats while a finished frame waits, so a
// stall on the result side fills both stages before req_ready drops.
// Digit code 10 is a blank tube; digit_0 is the leftmost tube.
// Time: HH MM SS, 12-hour mode maps hour 0 to 12 and blanks a leading zero.
// Temperature: magnitude of centi_degrees clamped to 9999, shown with two
// decimals, tenths or whole degrees (rounded, carries past the top tube are
// dropped); the colon is the decimal point. Negative readings go fully blank
// when bit 0 of time_ms/250 is set. Octet: 0..255 right-aligned. Blank
// requests clear every tube. colon_driven is set for temperature and octet.
// Registers (cfg_index): 0 hour_format_24 (reset 1), 1 temperature precision
// (reset 1). Write them only while no beat is in flight.
// ----------------------------------------------------------------------------
module tube_digit_frame_formatter (
	input  wire logic               clk,
	input  wire logic               arst_n,

	input  wire logic               cfg_we,
	input  wire logic               cfg_index,
	input  wire logic [1:0]         cfg_wdata,

	input  wire logic               req_valid,
	output      logic               req_ready,
	input  wire logic [1:0]         req_type,
	input  wire logic [4:0]         hour,
	input  wire logic [5:0]         minute,
	input  wire logic [5:0]         second,
	input  wire logic signed [15:0] centi_degrees,
	input  wire logic [7:0]         octet,
	input  wire logic [31:0]        time_ms,

	output      logic               rsp_valid,
	input  wire logic               rsp_ready,
	output      tdf_pkg::digit_t    digit_0,
	output      tdf_pkg::digit_t    digit_1,
	output      tdf_pkg::digit_t    digit_2,
	output      tdf_pkg::digit_t    digit_3,
	output      tdf_pkg::digit_t    digit_4,
	output      tdf_pkg::digit_t    digit_5,
	output      logic               colon_on,
	output      logic               colon_driven
);
	import tdf_pkg::*;

	// configuration
	logic        hour_format_24_q;
	logic [1:0]  temp_prec_q;

	// input stage
	logic              valid_s1;
	logic [1:0]        req_type_s1;
	logic [4:0]        hour_s1;
	logic [5:0]        minute_s1;
	logic [5:0]        second_s1;
	logic signed [15:0] centi_s1;
	logic [7:0]        octet_s1;
	logic [31:0]       time_ms_s1;

	// result stage
	logic    valid_s2;
	frame_t  frame_s2;

	frame_t  time_frame, temp_frame, octet_frame, next_frame;
	logic    s2_load;
	logic    s1_load;

	// --- configuration writes ---
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hour_format_24_q <= 1'b1;
			temp_prec_q      <= TDEC_TENTHS;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_HOUR_FORMAT: hour_format_24_q <= cfg_wdata[0];
				CFG_TEMP_PREC:   temp_prec_q      <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// --- handshake: result stage frees when empty or drained ---
	assign s2_load   = valid_s1 && (!valid_s2 || rsp_ready);
	assign req_ready = !valid_s1 || !valid_s2 || rsp_ready;
	assign s1_load   = req_valid && req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s1_load) begin
				valid_s1 <= 1'b1;
			end else if (s2_load) begin
				valid_s1 <= 1'b0;
			end
			if (s2_load) begin
				valid_s2 <= 1'b1;
			end else if (rsp_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_load) begin
			req_type_s1 <= req_type;
			hour_s1     <= hour;
			minute_s1   <= minute;
			second_s1   <= second;
			centi_s1    <= centi_degrees;
			octet_s1    <= octet;
			time_ms_s1  <= time_ms;
		end
		if (s2_load) begin
			frame_s2 <= next_frame;
		end
	end

	// --- formatters ---
	tdf_time_fmt u_time (
		.hour_format_24 (hour_format_24_q),
		.hour           (hour_s1),
		.minute         (minute_s1),
		.second         (second_s1),
		.frame          (time_frame)
	);

	tdf_temp_fmt u_temp (
		.temp_prec      (temp_prec_q),
		.centi_degrees  (centi_s1),
		.time_ms        (time_ms_s1),
		.frame          (temp_frame)
	);

	tdf_octet_fmt u_octet (
		.octet          (octet_s1),
		.frame          (octet_frame)
	);

	always_comb begin
		case (req_type_t'(req_type_s1))
			REQ_TIME:  next_frame = time_frame;
			REQ_TEMP:  next_frame = temp_frame;
			REQ_OCTET: next_frame = octet_frame;
			default: begin
				for (int i = 0; i < TUBE_COUNT; i++) begin
					next_frame.digit[i] = BLANK_DIGIT;
				end
				next_frame.colon_on     = 1'b0;
				next_frame.colon_driven = 1'b0;
			end
		endcase
	end

	// --- outputs ---
	assign rsp_valid    = valid_s2;
	assign digit_0      = frame_s2.digit[0];
	assign digit_1      = frame_s2.digit[1];
	assign digit_2      = frame_s2.digit[2];
	assign digit_3      = frame_s2.digit[3];
	assign digit_4      = frame_s2.digit[4];
	assign digit_5      = frame_s2.digit[5];
	assign colon_on     = frame_s2.colon_on;
	assign colon_driven = frame_s2.colon_driven;

	// --- checks ---
	// colon lamp is only lit by a view that drives it
	a_colon_driven: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (!colon_on || colon_driven))
		else $error("colon_on without colon_driven");

	// no bubbles: input back-pressure only when both stages hold beats
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> (valid_s1 && valid_s2 && !rsp_ready))
		else $error("req_ready low with free stage");

	// a beat in the input stage moves into a free result stage
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && (!valid_s2 || rsp_ready)) |=> valid_s2)
		else $error("input stage did not advance");

	// every tube code is a digit or blank
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (digit_0 <= BLANK_DIGIT && digit_1 <= BLANK_DIGIT &&
		               digit_2 <= BLANK_DIGIT && digit_3 <= BLANK_DIGIT &&
		               digit_4 <= BLANK_DIGIT && digit_5 <= BLANK_DIGIT))
		else $error("tube code out of range");

endmodule : tube_digit_frame_formatter
`default_nettype wire

// ===== bench/tube_digit_frame_formatter_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tube_digit_frame_formatter_tb
// Self-checking bench for the tube digit frame formatter. Requests go in on a
// valid/ready channel and frames come back one per request, in order. A frame
// predictor with its own register copy formats every accepted request and a
// checker compares each returned frame field by field. A short directed set
// hits the corner cases, then random traffic runs under three idle profiles
// and all register settings, with a long result-side stall and full drains.
// ----------------------------------------------------------------------------
module tube_digit_frame_formatter_tb;
	import tdf_pkg::*;

	localparam int          CLK_PERIOD   = 10;
	localparam int          RESET_CYCLES = 7;
	localparam int          BURST_LEN    = 85;     // random requests per register setting
	localparam int          STALL_CYCLES = 300;    // long result-side hold-off
	localparam int          TAIL_CYCLES  = 10;     // pipeline is two deep, leave margin
	localparam int          REPORT_LIMIT = 10;
	localparam int unsigned BLINK_MS     = 250;
	localparam longint      TIMEOUT_NS   = 2_000_000;

	// one request beat as the bench sees it
	typedef struct packed {
		req_type_t   kind;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic [15:0] centi;
		logic [7:0]  octet;
		logic [31:0] time_ms;
	} request_t;

	// ------------------------------------------------------------------------
	// Frame checker: predicts the frame for each accepted request and holds
	// the predictions until the matching frame beat shows up.
	// ------------------------------------------------------------------------
	class frame_checker;
		frame_t      pending_frames[$];
		logic        hour_24;
		logic [1:0]  decimals;
		int unsigned errors;

		function new();
			hour_24  = 1'b1;         // register reset values
			decimals = TDEC_TENTHS;
			errors   = 0;
		endfunction

		function void set_regs(logic h24, logic [1:0] dec);
			hour_24  = h24;
			decimals = dec;
		endfunction

		function frame_t format_frame(request_t r);
			frame_t      f;
			int unsigned h;
			int unsigned mag;
			int unsigned ip;
			int unsigned tenths;
			f.colon_on     = 1'b0;
			f.colon_driven = 1'b0;
			for (int i = 0; i < TUBE_COUNT; i++)
				f.digit[i] = BLANK_DIGIT;
			case (r.kind)
				REQ_TIME: begin
					h = r.hour;
					if (!hour_24) begin
						h = h % 12;
						if (h == 0)
							h = 12;
					end
					f.digit[0] = (!hour_24 && h < 10) ? BLANK_DIGIT : digit_t'(h / 10);
					f.digit[1] = digit_t'(h % 10);
					f.digit[2] = digit_t'(r.minute / 10);
					f.digit[3] = digit_t'(r.minute % 10);
					f.digit[4] = digit_t'(r.second / 10);
					f.digit[5] = digit_t'(r.second % 10);
				end
				REQ_TEMP: begin
					f.colon_driven = 1'b1;
					mag = r.centi[15] ? (32'h10000 - r.centi) : r.centi;
					if (mag > TEMP_CLAMP)
						mag = TEMP_CLAMP;
					// negative readings go dark on odd blink phases
					if (!(r.centi[15] && ((r.time_ms / BLINK_MS) % 2 == 1))) begin
						if (decimals >= TDEC_HUNDR) begin
							ip = mag / 100;
							f.digit[5] = digit_t'(mag % 10);
							f.digit[4] = digit_t'((mag / 10) % 10);
							f.digit[3] = digit_t'(ip % 10);
							if (ip >= 10)
								f.digit[2] = digit_t'((ip / 10) % 10);
							f.colon_on = 1'b1;
						end else if (decimals == TDEC_TENTHS) begin
							tenths = (mag + 5) / 10;
							ip     = tenths / 10;
							f.digit[4] = digit_t'(tenths % 10);
							f.digit[3] = digit_t'(ip % 10);
							if (ip >= 10)
								f.digit[2] = digit_t'((ip / 10) % 10);
							f.colon_on = 1'b1;
						end else begin
							ip = (mag + 50) / 100;
							f.digit[5] = digit_t'(ip % 10);
							if (ip >= 10)
								f.digit[4] = digit_t'((ip / 10) % 10);
						end
					end
				end
				REQ_OCTET: begin
					f.colon_driven = 1'b1;
					f.digit[5] = digit_t'(r.octet % 10);
					if (r.octet >= 10)
						f.digit[4] = digit_t'((r.octet / 10) % 10);
					if (r.octet >= 100)
						f.digit[3] = digit_t'((r.octet / 100) % 10);
				end
				default: ;   // blank request: all tubes dark
			endcase
			return f;
		endfunction

		function void note_request(request_t r);
			pending_frames.push_back(format_frame(r));
		endfunction

		function void flag(string what, int unsigned want, int unsigned got);
			errors++;
			if (errors <= REPORT_LIMIT)
				$display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
		endfunction

		function void check_frame(frame_t got);
			frame_t want;
			if (pending_frames.size() == 0) begin
				errors++;
				if (errors <= REPORT_LIMIT)
					$display("%0t: frame beat with no request outstanding", $time);
				return;
			end
			want = pending_frames.pop_front();
			for (int i = 0; i < TUBE_COUNT; i++)
				if (want.digit[i] !== got.digit[i])
					flag($sformatf("digit_%0d", i), want.digit[i], got.digit[i]);
			if (want.colon_on !== got.colon_on)
				flag("colon_on", want.colon_on, got.colon_on);
			if (want.colon_driven !== got.colon_driven)
				flag("colon_driven", want.colon_driven, got.colon_driven);
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// DUT hookup
	// ------------------------------------------------------------------------
	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [1:0]  cfg_wdata;
	logic        req_valid;
	logic        req_ready;
	logic [1:0]  req_type;
	logic [4:0]  hour;
	logic [5:0]  minute;
	logic [5:0]  second;
	logic [15:0] centi_degrees;
	logic [7:0]  octet;
	logic [31:0] time_ms;
	logic        rsp_valid;
	logic        rsp_ready;
	digit_t      digit_0, digit_1, digit_2, digit_3, digit_4, digit_5;
	logic        colon_on;
	logic        colon_driven;

	tube_digit_frame_formatter u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.req_valid     (req_valid),
		.req_ready     (req_ready),
		.req_type      (req_type),
		.hour          (hour),
		.minute        (minute),
		.second        (second),
		.centi_degrees (centi_degrees),
		.octet         (octet),
		.time_ms       (time_ms),
		.rsp_valid     (rsp_valid),
		.rsp_ready     (rsp_ready),
		.digit_0       (digit_0),
		.digit_1       (digit_1),
		.digit_2       (digit_2),
		.digit_3       (digit_3),
		.digit_4       (digit_4),
		.digit_5       (digit_5),
		.colon_on      (colon_on),
		.colon_driven  (colon_driven)
	);

	frame_checker chk = new();

	// idle odds in percent, changed by the stimulus between phases
	int send_idle_pct = 37;
	int recv_idle_pct = 62;
	// set by the stimulus to ask the receiver for one long hold-off
	int hold_cycles   = 0;

	always #(CLK_PERIOD / 2) clk = ~clk;

	// ------------------------------------------------------------------------
	// Receiver: random ready, or a long hold-off when asked. Counted in its
	// own process so the sender keeps offering beats meanwhile.
	// ------------------------------------------------------------------------
	initial begin : receiver
		rsp_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles != 0) begin
				rsp_ready <= 1'b0;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles = 0;
			end else begin
				rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Frame monitor. Values read right at the edge are the pre-edge ones,
	// since both the DUT and the bench update through nonblocking writes.
	always @(posedge clk) begin : frame_monitor
		frame_t got;
		if (arst_n && rsp_valid && rsp_ready) begin
			got.digit[0]     = digit_0;
			got.digit[1]     = digit_1;
			got.digit[2]     = digit_2;
			got.digit[3]     = digit_3;
			got.digit[4]     = digit_4;
			got.digit[5]     = digit_5;
			got.colon_on     = colon_on;
			got.colon_driven = colon_driven;
			chk.check_frame(got);
		end
	end

	// ------------------------------------------------------------------------
	// Driver tasks, all entered and left just after a rising edge
	// ------------------------------------------------------------------------
	function automatic request_t compose(req_type_t kind, int h, int m, int s,
			int cd, int oc, int unsigned ms);
		request_t r;
		r.kind    = kind;
		r.hour    = 5'(h);
		r.minute  = 6'(m);
		r.second  = 6'(s);
		r.centi   = 16'(cd);
		r.octet   = 8'(oc);
		r.time_ms = ms;
		return r;
	endfunction

	// Mostly legal times and temperatures near the clamp and rounding
	// edges, with full-range values mixed in so every bit moves.
	function automatic request_t random_request();
		request_t r;
		int       mag;
		r.kind    = req_type_t'($urandom_range(3));
		r.hour    = ($urandom_range(9) == 0) ? 5'($urandom) : 5'($urandom_range(23));
		r.minute  = ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(59));
		r.second  = ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(59));
		r.octet   = 8'($urandom);
		r.time_ms = $urandom;
		case ($urandom_range(3))
			0:       mag = $urandom_range(32768);
			1:       mag = $urandom_range(10100);
			2:       mag = $urandom_range(1200);
			default: mag = $urandom_range(9940, 10060);
		endcase
		r.centi = $urandom_range(1) ? 16'(-mag) : 16'(mag);
		return r;
	endfunction

	task automatic send_request(input request_t r);
		if ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		req_valid     <= 1'b1;
		req_type      <= r.kind;
		hour          <= r.hour;
		minute        <= r.minute;
		second        <= r.second;
		centi_degrees <= r.centi;
		octet         <= r.octet;
		time_ms       <= r.time_ms;
		do @(posedge clk); while (!req_ready);
		chk.note_request(r);
	endtask

	// sender stops and waits for every outstanding frame
	task automatic drain_frames();
		req_valid <= 1'b0;
		while (chk.pending_frames.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// both registers, one per cycle; only called with the pipe empty
	task automatic write_regs(input logic h24, input logic [1:0] dec);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_HOUR_FORMAT;
		cfg_wdata <= {1'b0, h24};
		@(posedge clk);
		cfg_index <= CFG_TEMP_PREC;
		cfg_wdata <= dec;
		@(posedge clk);
		cfg_we <= 1'b0;
		chk.set_regs(h24, dec);
	endtask

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	initial begin : stimulus
		logic [1:0] dec;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = CFG_HOUR_FORMAT;
		cfg_wdata     = '0;
		req_valid     = 1'b0;
		req_type      = REQ_BLANK;
		hour          = '0;
		minute        = '0;
		second        = '0;
		centi_degrees = '0;
		octet         = '0;
		time_ms       = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, registers at reset: 24-hour time, tenths
		send_request(compose(REQ_TIME, 23, 59, 59, 0, 0, 0));
		send_request(compose(REQ_TIME, 31, 63, 63, 0, 0, 0));     // out-of-range fields
		send_request(compose(REQ_TIME, 0, 0, 0, 0, 0, 0));
		send_request(compose(REQ_TEMP, 0, 0, 0, 9999, 0, 0));     // tenths carry to 1000
		send_request(compose(REQ_TEMP, 0, 0, 0, 32767, 0, 0));    // clamp
		send_request(compose(REQ_TEMP, 0, 0, 0, -32768, 0, 0));   // most negative, on phase
		send_request(compose(REQ_TEMP, 0, 0, 0, -5, 0, 250));     // off phase
		send_request(compose(REQ_TEMP, 0, 0, 0, -5, 0, 32'hFFFF_FFFF)); // clock at wrap
		send_request(compose(REQ_TEMP, 0, 0, 0, 994, 0, 0));      // ip below ten
		send_request(compose(REQ_TEMP, 0, 0, 0, 1000, 0, 0));
		send_request(compose(REQ_OCTET, 0, 0, 0, 0, 0, 0));
		send_request(compose(REQ_OCTET, 0, 0, 0, 0, 99, 0));
		send_request(compose(REQ_OCTET, 0, 0, 0, 0, 100, 0));
		send_request(compose(REQ_OCTET, 0, 0, 0, 0, 255, 0));
		send_request(compose(REQ_BLANK, 31, 63, 63, -1, 255, 32'hFFFF_FFFF));
		drain_frames();

		// 12-hour time, whole degrees
		write_regs(1'b0, TDEC_WHOLE);
		send_request(compose(REQ_TIME, 0, 0, 0, 0, 0, 0));        // midnight shows 12
		send_request(compose(REQ_TIME, 12, 30, 0, 0, 0, 0));
		send_request(compose(REQ_TIME, 9, 5, 7, 0, 0, 0));        // leading zero blanked
		send_request(compose(REQ_TIME, 31, 63, 63, 0, 0, 0));
		send_request(compose(REQ_TEMP, 0, 0, 0, 9999, 0, 0));     // whole carries to 100
		send_request(compose(REQ_TEMP, 0, 0, 0, 949, 0, 0));
		send_request(compose(REQ_TEMP, 0, 0, 0, -950, 0, 499));
		drain_frames();

		// hundredths through the spare code
		write_regs(1'b1, 2'd3);
		send_request(compose(REQ_TEMP, 0, 0, 0, 9999, 0, 0));
		send_request(compose(REQ_TEMP, 0, 0, 0, -1234, 0, 0));
		send_request(compose(REQ_TEMP, 0, 0, 0, 5, 0, 0));
		drain_frames();

		// random traffic: three idle profiles, every precision code in each, both hour formats
		for (int regime = 0; regime < 3; regime++) begin
			case (regime)
				0: begin
					send_idle_pct = 37;
					recv_idle_pct = 62;
				end
				1: begin
					send_idle_pct = 62;
					recv_idle_pct = 37;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int b = 0; b < 4; b++) begin
				dec = 2'(b);
				write_regs(1'((b + regime) % 2), dec);
				// one long receiver stall: the two stages fill and req_ready drops
				if (regime == 0 && b == 0)
					hold_cycles = STALL_CYCLES;
				for (int k = 0; k < BURST_LEN; k++)
					send_request(random_request());
				drain_frames();
			end
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (chk.errors == 0 && chk.pending_frames.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// hard stop if the handshake hangs
	initial begin : watchdog
		#(TIMEOUT_NS);
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
